### hw/rtl/box_min_max_filter_2d_macros.svh
// Assertion macros shared by the checker of the box min/max filter.
`ifndef BOX_MIN_MAX_FILTER_2D_MACROS_SVH
`define BOX_MIN_MAX_FILTER_2D_MACROS_SVH

// Same-cycle implication, sampled on the rising clock and quiet during reset.
`define BMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock and quiet during reset.
`define BMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bmm_pkg.sv
// Shared constants, codes and types of the box min/max filter.
package bmm_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_RADIUS_DEF = 8;
  localparam int unsigned PIXEL_BITS_DEF = 16;

  localparam int unsigned WIDTH_REG_W  = 12;
  localparam int unsigned HEIGHT_REG_W = 16;
  localparam int unsigned RADIUS_REG_W = 4;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned ROW_W        = 17;

  localparam int unsigned WIDTH_RESET  = 2048;
  localparam int unsigned HEIGHT_RESET = 1024;
  localparam int unsigned RADIUS_RESET = 6;

  localparam int unsigned FIFO_DEPTH = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_RADIUS = 3'd2,
    REG_MODE   = 3'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef struct packed {
    logic has_out;
    logic last;
    logic mode_max;
  } item_ctrl_t;

endpackage

### hw/rtl/bmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/bmm_fifo.sv
// Small first-in first-out queue between the front and back parts.
module bmm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = bmm_pkg::FIFO_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           push_data_i,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic [WIDTH-1:0]           head_o,
  output logic [$clog2(DEPTH+1)-1:0] free_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH-1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH-1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rptr_q];
  assign free_o  = CNT_W'(DEPTH) - cnt_q;

endmodule

### hw/rtl/bmm_front.sv
// Front part: stream position, row buffers and the vertical column extreme.
module bmm_front #(
  parameter int unsigned MAX_WIDTH  = bmm_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_RADIUS = bmm_pkg::MAX_RADIUS_DEF,
  parameter int unsigned PIXEL_BITS = bmm_pkg::PIXEL_BITS_DEF,
  parameter int unsigned WCNT_W     = $clog2(MAX_WIDTH+1),
  parameter int unsigned RAD_W      = $clog2(MAX_RADIUS+1),
  parameter int unsigned FREE_W     = $clog2(bmm_pkg::FIFO_DEPTH+1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              operation_i,
  input  logic [PIXEL_BITS-1:0]             pixel_i,
  input  logic [WCNT_W-1:0]                 w_i,
  input  logic [bmm_pkg::HEIGHT_REG_W-1:0]  h_i,
  input  logic [RAD_W-1:0]                  r_i,
  input  logic                              mode_i,
  input  logic [FREE_W-1:0]                 free_i,
  output logic                              push_o,
  output logic [PIXEL_BITS-1:0]             push_col_o,
  output logic [2*MAX_RADIUS:0]             push_mask_o,
  output bmm_pkg::item_ctrl_t               push_ctrl_o
);

  localparam int unsigned WIN    = 2*MAX_RADIUS + 1;
  localparam int unsigned RING   = 2*MAX_RADIUS + 2;
  localparam int unsigned SLOT_W = $clog2(RING);
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned NG     = (WIN + 3) / 4;
  localparam int unsigned ROW_W  = bmm_pkg::ROW_W;
  localparam int unsigned H_W    = bmm_pkg::HEIGHT_REG_W;
  localparam int unsigned DLY_W  = $clog2(MAX_RADIUS*MAX_WIDTH + MAX_RADIUS + 1);

  function automatic logic [PIXEL_BITS-1:0] pick(input logic mx,
                                                 input logic [PIXEL_BITS-1:0] a,
                                                 input logic [PIXEL_BITS-1:0] b);
    if (mx) return (a > b) ? a : b;
    return (a < b) ? a : b;
  endfunction

  // Stream position.
  logic [COL_W-1:0]  in_col_q, in_col_d;
  logic [ROW_W-1:0]  in_row_q, in_row_d;
  logic [SLOT_W-1:0] wslot_q, wslot_d;
  logic [COL_W-1:0]  ox_q, ox_d;
  logic [H_W-1:0]    oy_q, oy_d;
  logic [DLY_W-1:0]  pre_q, pre_d, delay;

  logic accept, in_frame, advance, wr_en, load, has_out, last;
  logic [WIN-1:0] vmask_d, hmask_d;

  // Stage 1 and stage 2 registers.
  logic                  v1_q, v2_q;
  logic [PIXEL_BITS-1:0] pix1_q;
  logic [WIN-1:0]        vmask1_q, hmask1_q, hmask2_q;
  logic [SLOT_W-1:0]     wslot1_q;
  bmm_pkg::item_ctrl_t   ctrl1_q, ctrl2_q;
  logic [PIXEL_BITS-1:0] part_d [NG];
  logic [PIXEL_BITS-1:0] part2_q [NG];
  logic [PIXEL_BITS-1:0] ram_rd [RING];
  logic [PIXEL_BITS-1:0] col_d;

  // Room in the queue must cover items still in the two stages.
  assign in_ready_o = (free_i > FREE_W'(v1_q) + FREE_W'(v2_q));
  assign accept     = in_valid_i && in_ready_o;
  assign in_frame   = ({1'b0, h_i} > in_row_q);
  assign advance    = accept && !(in_frame && (operation_i == bmm_pkg::OP_DRAIN));
  assign wr_en      = advance && in_frame;
  assign load       = advance && (in_row_q >= ROW_W'(r_i));
  // Results start once radius rows plus radius pixels have gone by. The count
  // saturates there, which also holds when the radius is not below the width.
  assign delay      = DLY_W'(r_i) * DLY_W'(w_i) + DLY_W'(r_i);
  assign has_out    = advance && (pre_q == delay);
  assign last       = has_out && (WCNT_W'(ox_q) == w_i - WCNT_W'(1)) &&
                      (oy_q == h_i - H_W'(1));

  always_comb begin
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    wslot_d  = wslot_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    pre_d    = pre_q;
    if (advance) begin
      if (WCNT_W'(in_col_q) + WCNT_W'(1) >= w_i) begin
        in_col_d = '0;
        in_row_d = in_row_q + ROW_W'(1);
        wslot_d  = (wslot_q == SLOT_W'(RING-1)) ? '0 : wslot_q + SLOT_W'(1);
      end else begin
        in_col_d = in_col_q + COL_W'(1);
      end
      if (pre_q != delay) begin
        pre_d = pre_q + DLY_W'(1);
      end
      if (has_out) begin
        if (WCNT_W'(ox_q) + WCNT_W'(1) >= w_i) begin
          ox_d = '0;
          oy_d = oy_q + H_W'(1);
        end else begin
          ox_d = ox_q + COL_W'(1);
        end
      end
      if (last) begin
        in_col_d = '0;
        in_row_d = '0;
        wslot_d  = '0;
        ox_d     = '0;
        oy_d     = '0;
        pre_d    = '0;
      end
    end
  end

  // Row t back from the current input row joins the column if it lies in the
  // frame and within the vertical window; entry i of the column window joins
  // the output if its column lies in the frame and within the horizontal window.
  always_comb begin
    int xs;
    xs = 0;
    for (int t = 0; t < WIN; t++) begin
      vmask_d[t] = (t <= 2*int'(r_i)) && (int'(in_row_q) >= t) &&
                   ((int'(in_row_q) - t) < int'(h_i));
    end
    for (int i = 0; i < WIN; i++) begin
      xs = int'(ox_q) + int'(r_i) - i;
      hmask_d[i] = (i <= 2*int'(r_i)) && (xs >= 0) && (xs < int'(w_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
      wslot_q  <= '0;
      ox_q     <= '0;
      oy_q     <= '0;
      pre_q    <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
    end else begin
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
      wslot_q  <= wslot_d;
      ox_q     <= ox_d;
      oy_q     <= oy_d;
      pre_q    <= pre_d;
      v1_q     <= load;
      v2_q     <= v1_q;
    end
  end

  for (genvar s = 0; s < RING; s++) begin : g_row
    bmm_ram #(
      .WIDTH(PIXEL_BITS),
      .DEPTH(MAX_WIDTH)
    ) u_row_ram (
      .clk_i  (clk_i),
      .we_i   (wr_en && (wslot_q == SLOT_W'(s))),
      .waddr_i(in_col_q),
      .wdata_i(pixel_i),
      .re_i   (load),
      .raddr_i(in_col_q),
      .rdata_o(ram_rd[s])
    );
  end

  always_ff @(posedge clk_i) begin
    pix1_q   <= pixel_i;
    vmask1_q <= vmask_d;
    hmask1_q <= hmask_d;
    wslot1_q <= wslot_q;
    ctrl1_q  <= '{has_out: has_out, last: last, mode_max: mode_i};
    part2_q  <= part_d;
    hmask2_q <= hmask1_q;
    ctrl2_q  <= ctrl1_q;
  end

  // Stage 1: pick each row from its ring slot and reduce in groups of four.
  always_comb begin
    logic [PIXEL_BITS-1:0] neutral, cand;
    int idx;
    neutral = ctrl1_q.mode_max ? '0 : '1;
    cand    = '0;
    idx     = 0;
    for (int g = 0; g < int'(NG); g++) begin
      part_d[g] = neutral;
    end
    for (int t = 0; t < WIN; t++) begin
      idx = int'(wslot1_q) + int'(RING) - t;
      if (idx >= int'(RING)) idx = idx - int'(RING);
      cand = (t == 0) ? pix1_q : ram_rd[SLOT_W'(idx)];
      if (vmask1_q[t]) begin
        part_d[t/4] = pick(ctrl1_q.mode_max, part_d[t/4], cand);
      end
    end
  end

  // Stage 2: finish the column extreme.
  always_comb begin
    col_d = ctrl2_q.mode_max ? '0 : '1;
    for (int g = 0; g < int'(NG); g++) begin
      col_d = pick(ctrl2_q.mode_max, col_d, part2_q[g]);
    end
  end

  assign push_o      = v2_q;
  assign push_col_o  = col_d;
  assign push_mask_o = hmask2_q;
  assign push_ctrl_o = ctrl2_q;

endmodule

### hw/rtl/bmm_back.sv
// Back part: column extreme window, horizontal reduction and output register.
module bmm_back #(
  parameter int unsigned MAX_RADIUS = bmm_pkg::MAX_RADIUS_DEF,
  parameter int unsigned PIXEL_BITS = bmm_pkg::PIXEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  logic [PIXEL_BITS-1:0] head_col_i,
  input  logic [2*MAX_RADIUS:0] head_mask_i,
  input  bmm_pkg::item_ctrl_t   head_ctrl_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIXEL_BITS-1:0] value_o,
  output logic                  last_o
);

  localparam int unsigned WIN = 2*MAX_RADIUS + 1;
  localparam int unsigned NG  = (WIN + 3) / 4;

  function automatic logic [PIXEL_BITS-1:0] pick(input logic mx,
                                                 input logic [PIXEL_BITS-1:0] a,
                                                 input logic [PIXEL_BITS-1:0] b);
    if (mx) return (a > b) ? a : b;
    return (a < b) ? a : b;
  endfunction

  logic                  adv;
  logic [PIXEL_BITS-1:0] win_q [WIN];
  logic                  b0_valid_q, b1_valid_q, out_valid_q;
  logic [WIN-1:0]        b0_mask_q;
  bmm_pkg::item_ctrl_t   b0_ctrl_q, b1_ctrl_q;
  logic [PIXEL_BITS-1:0] part_d [NG];
  logic [PIXEL_BITS-1:0] part1_q [NG];
  logic [PIXEL_BITS-1:0] value_d, value_q;
  logic                  last_q;

  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_valid_q  <= 1'b0;
      b1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      b0_valid_q  <= pop_o && head_ctrl_i.has_out;
      b1_valid_q  <= b0_valid_q;
      out_valid_q <= b1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      win_q[0] <= head_col_i;
      for (int i = 1; i < WIN; i++) begin
        win_q[i] <= win_q[i-1];
      end
      b0_mask_q <= head_mask_i;
      b0_ctrl_q <= head_ctrl_i;
    end
    if (adv) begin
      part1_q   <= part_d;
      b1_ctrl_q <= b0_ctrl_q;
      value_q   <= value_d;
      last_q    <= b1_ctrl_q.last;
    end
  end

  always_comb begin
    for (int g = 0; g < int'(NG); g++) begin
      part_d[g] = b0_ctrl_q.mode_max ? '0 : '1;
    end
    for (int i = 0; i < WIN; i++) begin
      if (b0_mask_q[i]) begin
        part_d[i/4] = pick(b0_ctrl_q.mode_max, part_d[i/4], win_q[i]);
      end
    end
  end

  always_comb begin
    value_d = b1_ctrl_q.mode_max ? '0 : '1;
    for (int g = 0; g < int'(NG); g++) begin
      value_d = pick(b1_ctrl_q.mode_max, value_d, part1_q[g]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

endmodule

### hw/rtl/box_min_max_filter_2d.sv
// Top level of the streaming 2D box minimum / maximum filter.
//
//   Channel  Direction  Handshake                  Payload
//   cfg      in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//   in       in         in_valid_i / in_ready_o    operation_i, pixel_i
//   out      out        out_valid_o / out_ready_i  value_o, last_o
//
// One input transfer is taken per clock while the output side keeps up; the
// front part and the row buffer ports sustain one pixel per cycle.
// A result passes the two front stages, the queue and the back part's window,
// partial-result and output registers before it is presented.
// The eight-entry queue between front and back lets input continue while a
// result waits at the output; input stalls once the queue and the two front
// stages together hold eight items.
// Reset clears all position counters and loads the register defaults; the
// row buffers need no clearing, as rows are always written before use.
//
// Each pixel is written into a ring of 2*MAX_RADIUS+2 row buffers. In the same
// cycle all buffers are read at that column, and the column extreme over the
// vertical window is formed in two stages. The back part shifts these column
// extremes through a window of 2*MAX_RADIUS+1 registers and reduces the
// entries that fall inside the clipped horizontal window.
module box_min_max_filter_2d #(
  parameter int unsigned MAX_WIDTH  = bmm_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_RADIUS = bmm_pkg::MAX_RADIUS_DEF,
  parameter int unsigned PIXEL_BITS = bmm_pkg::PIXEL_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bmm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bmm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           operation_i,
  input  logic [PIXEL_BITS-1:0]          pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [PIXEL_BITS-1:0]          value_o,
  output logic                           last_o
);

  localparam int unsigned WCNT_W = $clog2(MAX_WIDTH+1);
  localparam int unsigned RAD_W  = $clog2(MAX_RADIUS+1);
  localparam int unsigned WIN    = 2*MAX_RADIUS + 1;
  localparam int unsigned FREE_W = $clog2(bmm_pkg::FIFO_DEPTH+1);
  localparam int unsigned ITEM_W = PIXEL_BITS + WIN + $bits(bmm_pkg::item_ctrl_t);
  localparam int unsigned H_W    = bmm_pkg::HEIGHT_REG_W;

  localparam int unsigned W_RST = (bmm_pkg::WIDTH_RESET > MAX_WIDTH) ?
                                  MAX_WIDTH : bmm_pkg::WIDTH_RESET;
  localparam int unsigned R_RST = (bmm_pkg::RADIUS_RESET > MAX_RADIUS) ?
                                  MAX_RADIUS : bmm_pkg::RADIUS_RESET;

  // Registers are kept in their effective form: out-of-range values are
  // clamped as they are written.
  logic [WCNT_W-1:0] w_q, w_d;
  logic [H_W-1:0]    h_q, h_d;
  logic [RAD_W-1:0]  r_q, r_d;
  logic              mode_q, mode_d;

  logic [bmm_pkg::WIDTH_REG_W-1:0]  wr_width;
  logic [bmm_pkg::RADIUS_REG_W-1:0] wr_radius;

  assign cfg_ready_o = 1'b1;
  assign wr_width    = cfg_data_i[bmm_pkg::WIDTH_REG_W-1:0];
  assign wr_radius   = cfg_data_i[bmm_pkg::RADIUS_REG_W-1:0];

  always_comb begin
    w_d    = w_q;
    h_d    = h_q;
    r_d    = r_q;
    mode_d = mode_q;
    if (cfg_valid_i) begin
      case (bmm_pkg::cfg_reg_e'(cfg_index_i))
        bmm_pkg::REG_WIDTH: begin
          if (wr_width == '0) begin
            w_d = WCNT_W'(1);
          end else if (int'(wr_width) > int'(MAX_WIDTH)) begin
            w_d = WCNT_W'(MAX_WIDTH);
          end else begin
            w_d = WCNT_W'(wr_width);
          end
        end
        bmm_pkg::REG_HEIGHT: begin
          h_d = (cfg_data_i[H_W-1:0] == '0) ? H_W'(1) : cfg_data_i[H_W-1:0];
        end
        bmm_pkg::REG_RADIUS: begin
          r_d = (int'(wr_radius) > int'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) :
                                                       RAD_W'(wr_radius);
        end
        bmm_pkg::REG_MODE: begin
          mode_d = cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= WCNT_W'(W_RST);
      h_q    <= H_W'(bmm_pkg::HEIGHT_RESET);
      r_q    <= RAD_W'(R_RST);
      mode_q <= 1'b0;
    end else begin
      w_q    <= w_d;
      h_q    <= h_d;
      r_q    <= r_d;
      mode_q <= mode_d;
    end
  end

  logic                  push, pop, empty;
  logic [FREE_W-1:0]     free;
  logic [PIXEL_BITS-1:0] push_col, head_col;
  logic [WIN-1:0]        push_mask, head_mask;
  bmm_pkg::item_ctrl_t   push_ctrl, head_ctrl;
  logic [ITEM_W-1:0]     head_item;

  bmm_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS),
    .PIXEL_BITS(PIXEL_BITS),
    .WCNT_W    (WCNT_W),
    .RAD_W     (RAD_W),
    .FREE_W    (FREE_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .operation_i(operation_i),
    .pixel_i    (pixel_i),
    .w_i        (w_q),
    .h_i        (h_q),
    .r_i        (r_q),
    .mode_i     (mode_q),
    .free_i     (free),
    .push_o     (push),
    .push_col_o (push_col),
    .push_mask_o(push_mask),
    .push_ctrl_o(push_ctrl)
  );

  bmm_fifo #(
    .WIDTH(ITEM_W),
    .DEPTH(bmm_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({push_col, push_mask, push_ctrl}),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head_item),
    .free_o     (free)
  );

  assign {head_col, head_mask, head_ctrl} = head_item;

  bmm_back #(
    .MAX_RADIUS(MAX_RADIUS),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_col_i (head_col),
    .head_mask_i(head_mask),
    .head_ctrl_i(head_ctrl),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o    (value_o),
    .last_o     (last_o)
  );

endmodule

### hw/rtl/bmm_checker.sv
// Port-level checker of the box min/max filter and its bind to the top level.
`include "box_min_max_filter_2d_macros.svh"

module bmm_checker #(
  parameter int unsigned PIXEL_BITS = bmm_pkg::PIXEL_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [PIXEL_BITS-1:0] value_o,
  input logic                  last_o
);

  `BMM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `BMM_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(value_o) && $stable(last_o), "result changed while stalled")
  `BMM_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_o, "configuration write refused")
  `BMM_ASSERT_NOW(a_reset_quiet, $rose(rst_ni), !out_valid_o, "result right after reset")

endmodule

bind box_min_max_filter_2d bmm_checker #(.PIXEL_BITS(PIXEL_BITS)) u_bmm_checker (.*);

### bench/tb_box_min_max_filter_2d.sv
// Self-checking testbench for the streaming 2D box minimum / maximum filter.
module tb_box_min_max_filter_2d;
  import bmm_pkg::*;

  localparam int unsigned RING_ROWS   = 2 * MAX_RADIUS_DEF + 2;
  localparam int unsigned ROW_CAP     = MAX_WIDTH_DEF;
  localparam int unsigned WATCHDOG    = 20000;
  localparam int unsigned SETTLE      = 12;
  localparam int unsigned RANDOM_GOAL = 800;

  typedef struct packed {
    op_e         op;
    logic [15:0] pixel;
  } pixel_item_t;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } filter_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  operation_i;
  logic [15:0]           pixel_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [15:0]           value_o;
  logic                  last_o;

  box_min_max_filter_2d dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .last_o      (last_o)
  );

  // Stimulus waiting for the driver, and results the filter still owes us.
  pixel_item_t    pending_items[$];
  filter_result_t expected_pixels[$];

  int unsigned error_count  = 0;
  int unsigned result_count = 0;
  int unsigned frame_count;
  int unsigned random_items;
  int unsigned idle_cycles  = 0;

  // ---------------------------------------------------------------------------
  // Shadow of the filter: register file, ring of row buffers and stream
  // position. It is advanced once per accepted input transfer.
  // ---------------------------------------------------------------------------
  logic [11:0] shadow_width;
  logic [15:0] shadow_height;
  logic [3:0]  shadow_radius;
  logic        shadow_max;
  logic [15:0] ring_rows[RING_ROWS * ROW_CAP];
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned out_pos;

  // Out-of-range register contents are clamped the same way the block does.
  function automatic int unsigned eff_width(logic [11:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return raw;
  endfunction

  function automatic int unsigned eff_height(logic [15:0] raw);
    return (raw == 0) ? 1 : raw;
  endfunction

  function automatic int unsigned eff_radius(logic [3:0] raw);
    return (raw > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : raw;
  endfunction

  function automatic void shadow_write(cfg_reg_e idx, logic [15:0] data);
    case (idx)
      REG_WIDTH:  shadow_width  = data[11:0];
      REG_HEIGHT: shadow_height = data;
      REG_RADIUS: shadow_radius = data[3:0];
      REG_MODE:   shadow_max    = data[0];
      default: ;
    endcase
  endfunction

  // Min or max over the window around raster index k, clipped at the borders.
  function automatic logic [15:0] window_extreme(int unsigned k, int unsigned w,
                                                 int unsigned h, int unsigned r);
    int unsigned oy, ox, y0, y1, x0, x1;
    logic [15:0] acc, s;
    oy  = k / w;
    ox  = k % w;
    y0  = (oy >= r) ? oy - r : 0;
    y1  = (oy + r < h) ? oy + r : h - 1;
    x0  = (ox >= r) ? ox - r : 0;
    x1  = (ox + r < w) ? ox + r : w - 1;
    acc = shadow_max ? 16'h0000 : 16'hFFFF;
    for (int unsigned y = y0; y <= y1; y++) begin
      for (int unsigned x = x0; x <= x1; x++) begin
        s = ring_rows[(y % RING_ROWS) * ROW_CAP + x];
        if (shadow_max ? (s > acc) : (s < acc)) acc = s;
      end
    end
    return acc;
  endfunction

  function automatic void filter_step(pixel_item_t it);
    int unsigned w, h, r, k;
    longint unsigned pos, delay, total;
    filter_result_t res;
    w = eff_width(shadow_width);
    h = eff_height(shadow_height);
    r = eff_radius(shadow_radius);
    if (row_pos < h) begin
      // An early drain is dropped without moving the stream position.
      if (it.op == OP_DRAIN) return;
      ring_rows[(row_pos % RING_ROWS) * ROW_CAP + col_pos] = it.pixel;
    end
    pos   = longint'(row_pos) * w + col_pos;
    delay = longint'(r) * w + r;
    total = longint'(w) * h;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (pos < delay) return;
    k = out_pos;
    res.last = (longint'(k) + 1 >= total);
    if (res.last) k = 32'(total - 1);
    res.value = window_extreme(k, w, h, r);
    expected_pixels.push_back(res);
    if (res.last) begin
      col_pos = 0;
      row_pos = 0;
      out_pos = 0;
    end else begin
      out_pos++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and reset. Reset is applied once, at the start.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Input driver. It takes items from the pending queue and inserts random
  // gaps; the burst flag switches gaps off for whole frames.
  // ---------------------------------------------------------------------------
  int unsigned send_gap;
  bit          burst_mode;

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_item_t nxt;
    int unsigned roll;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      operation_i <= OP_PIXEL;
      pixel_i     <= '0;
      send_gap    <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        filter_step(pixel_item_t'{op: op_e'(operation_i), pixel: pixel_i});
      end
      // A new item may be offered only once the current one has been taken.
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() != 0) begin
          nxt = pending_items.pop_front();
          in_valid_i  <= 1'b1;
          operation_i <= nxt.op;
          pixel_i     <= nxt.pixel;
          roll = $urandom_range(0, 19);
          if (burst_mode || roll < 12) send_gap <= 0;
          else if (roll < 19) send_gap <= $urandom_range(1, 3);
          else send_gap <= $urandom_range(10, 30);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side. The ready pattern runs in its own process; one long hold-off
  // is forced while the sender still has plenty queued, so the internal
  // queue fills and the input must stall.
  // ---------------------------------------------------------------------------
  int unsigned hold_cycles;
  bit          long_hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned roll;
    if (!rst_ni) begin
      out_ready_i    <= 1'b0;
      hold_cycles    <= 0;
      long_hold_done <= 1'b0;
    end else if (!long_hold_done && pending_items.size() > 60) begin
      out_ready_i    <= 1'b0;
      hold_cycles    <= 300;
      long_hold_done <= 1'b1;
    end else if (hold_cycles != 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      roll = $urandom_range(0, 39);
      out_ready_i <= 1'b1;
      if (!burst_mode && roll < 6) begin
        out_ready_i <= 1'b0;
        hold_cycles <= $urandom_range(0, 2);
      end else if (!burst_mode && roll == 6) begin
        out_ready_i <= 1'b0;
        hold_cycles <= $urandom_range(10, 40);
      end
    end
  end

  // Result checker: every output transfer is compared with the oldest
  // expectation.
  always @(posedge clk_i) begin
    filter_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      result_count <= result_count + 1;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result value=%h last=%b", $time, value_o, last_o);
        error_count <= error_count + 1;
      end else begin
        exp_res = expected_pixels.pop_front();
        if (exp_res.value !== value_o || exp_res.last !== last_o) begin
          $display("%0t: mismatch expected value=%h last=%b, actual value=%h last=%b",
                   $time, exp_res.value, exp_res.last, value_o, last_o);
          error_count <= error_count + 1;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------

  // Waits until all stimulus is sent and every expected result has arrived, then
  // lets the latency pass, since a drain that makes no result may still be moving through the block.
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid_i || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Offers one register write and waits for its transfer; the caller drops
  // the valid after the last write of a sequence.
  task automatic write_register(cfg_reg_e idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_write(idx, data);
  endtask

  function automatic logic [15:0] random_sample();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // Queues one whole frame: pixels with a few ignored early drains mixed in,
  // then the drain items that flush the window, some of them late pixels.
  task automatic queue_frame(logic [11:0] w_raw, logic [15:0] h_raw, logic [3:0] r_raw,
                             logic mode_max, bit reconfigure, bit counted);
    int unsigned w, h, r, npix, ndrain;
    w = eff_width(w_raw);
    h = eff_height(h_raw);
    r = eff_radius(r_raw);
    npix   = w * h;
    ndrain = r * w + r;
    if (reconfigure) begin
      wait_idle();
      // Upper data bits beyond each register's width are don't-care.
      write_register(REG_WIDTH,  {4'($urandom), w_raw});
      write_register(REG_HEIGHT, h_raw);
      write_register(REG_RADIUS, {12'($urandom), r_raw});
      write_register(REG_MODE,   {15'($urandom), mode_max});
      cfg_valid_i <= 1'b0;
    end
    burst_mode = ($urandom_range(0, 4) == 0);
    for (int unsigned i = 0; i < npix; i++) begin
      if ($urandom_range(0, 24) == 0)
        pending_items.push_back(pixel_item_t'{op: OP_DRAIN, pixel: random_sample()});
      pending_items.push_back(pixel_item_t'{op: OP_PIXEL, pixel: random_sample()});
    end
    for (int unsigned i = 0; i < ndrain; i++) begin
      if ($urandom_range(0, 5) == 0)
        pending_items.push_back(pixel_item_t'{op: OP_PIXEL, pixel: random_sample()});
      else
        pending_items.push_back(pixel_item_t'{op: OP_DRAIN, pixel: random_sample()});
    end
    frame_count++;
    if (counted) random_items += npix + ndrain;
    // Keep the queue from growing far ahead of the block.
    while (pending_items.size() > 400) @(posedge clk_i);
  endtask

  initial begin
    int unsigned w, h, r;
    bit          m, reconf;
    frame_count  = 0;
    random_items = 0;
    burst_mode   = 1'b0;
    // Shadow registers follow the block's reset defaults.
    shadow_width  = WIDTH_RESET;
    shadow_height = HEIGHT_RESET;
    shadow_radius = RADIUS_RESET;
    shadow_max    = 1'b0;
    col_pos = 0;
    row_pos = 0;
    out_pos = 0;
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_WIDTH;
    cfg_data_i  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames: tiny frames in both modes, zero registers clamped up,
    // an oversized radius clamped down, radius not below the width, and one
    // larger frame that keeps the sender well ahead of the block.
    queue_frame(12'd3, 16'd2, 4'd1, 1'b0, 1'b1, 1'b0);
    queue_frame(12'd3, 16'd2, 4'd1, 1'b1, 1'b1, 1'b0);
    queue_frame(12'd0, 16'd0, 4'd0, 1'b0, 1'b1, 1'b0);
    queue_frame(12'd0, 16'd0, 4'd15, 1'b1, 1'b1, 1'b0);
    queue_frame(12'd5, 16'd4, 4'd8, 1'b0, 1'b1, 1'b0);
    queue_frame(12'd5, 16'd4, 4'd8, 1'b0, 1'b0, 1'b0);
    queue_frame(12'd1, 16'd40, 4'd1, 1'b0, 1'b1, 1'b0);
    queue_frame(12'd2, 16'd6, 4'd8, 1'b1, 1'b1, 1'b0);
    queue_frame(12'd24, 16'd8, 4'd2, 1'b0, 1'b1, 1'b0);

    // Random frames, mostly small, sometimes run back to back without a
    // register change, which then repeat the previous frame's geometry.
    w = 24;
    h = 8;
    r = 2;
    m = 1'b0;
    while (random_items < RANDOM_GOAL) begin
      reconf = ($urandom_range(0, 3) != 0);
      if (reconf) begin
        w = $urandom_range(1, 24);
        h = $urandom_range(1, 12);
        r = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
        m = 1'($urandom_range(0, 1));
      end
      queue_frame(12'(w), 16'(h), 4'(r), m, reconf, 1'b1);
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d frames (%0d random stream items) and checked %0d results,",
             frame_count, random_items, result_count);
    $display("with min and max modes, clamped registers and border-clipped windows.");
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/bmm_pkg.sv
hw/rtl/bmm_ram.sv
hw/rtl/bmm_fifo.sv
hw/rtl/bmm_front.sv
hw/rtl/bmm_back.sv
hw/rtl/box_min_max_filter_2d.sv
hw/rtl/bmm_checker.sv
bench/tb_box_min_max_filter_2d.sv
